// ===== hw/rtl/ostwi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ostwi_pkg;

  localparam int READ_BITS_DEF = 23;
  localparam int CMD_BITS = 8;
  localparam int GAP_PERIODS = 10;
  localparam int RAW_W = 23;
  localparam int CODE_W = 18;
  localparam int INDEX_W = 16;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_READ_HALF  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_HALF = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DONT_CARE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MISS_MIN   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_MISS_MAX   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_POWER_DOWN = 3'd7;

  typedef struct packed {
    logic [15:0]       read_half_ticks;
    logic [15:0]       write_half_ticks;
    logic [9:0]        holdoff_ms;
    logic [9:0]        timeout_ms;
    logic [CODE_W-1:0] dont_care_code;
    logic [CODE_W-1:0] missing_min;
    logic [CODE_W-1:0] missing_max;
    logic [RAW_W-1:0]  power_down_code;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] cmd_byte;
    logic       sdio_in;
    logic       ms_tick;
  } item_t;

  typedef struct packed {
    logic               sck_level;
    logic               sdio_drive;
    logic               sdio_enable;
    logic               busy_res;
    logic               word_valid;
    logic [RAW_W-1:0]   raw_word;
    logic               index_valid;
    logic [INDEX_W-1:0] pen_index;
    logic               pen_leave;
    logic               pen_timeout;
    logic               reinit_needed;
  } res_t;

  typedef enum logic [11:0] {
    PH_IDLE  = 12'b0000_0000_0001,
    PH_R_PRE = 12'b0000_0000_0010,
    PH_R_SHI = 12'b0000_0000_0100,
    PH_R_SLO = 12'b0000_0000_1000,
    PH_R_BHI = 12'b0000_0001_0000,
    PH_R_BLO = 12'b0000_0010_0000,
    PH_W_PRE = 12'b0000_0100_0000,
    PH_W_SHI = 12'b0000_1000_0000,
    PH_W_SLO = 12'b0001_0000_0000,
    PH_W_BHI = 12'b0010_0000_0000,
    PH_W_BLO = 12'b0100_0000_0000,
    PH_W_GAP = 12'b1000_0000_0000
  } phase_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ostwi_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ostwi_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  ostwi_pkg::item_t item,
  output logic            head_valid,
  output ostwi_pkg::item_t head,
  input  wire             pop
);

  ostwi_pkg::item_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;

  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ostwi_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ostwi_back #(
  parameter int READ_BITS = ostwi_pkg::READ_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  ostwi_pkg::cfg_t  cfg,
  input  wire              head_valid,
  input  ostwi_pkg::item_t head,
  output logic             pop,
  input  wire              out_stall,
  output logic             out_valid,
  output ostwi_pkg::res_t  res
);

  localparam int SW = READ_BITS;
  localparam int BCW = $clog2(READ_BITS + 1);

  ostwi_pkg::phase_t phase, phase_next;
  logic [BCW-1:0]    bit_count, bit_count_next, bc_inc;
  logic [15:0]       tick_count, tick_count_next;
  logic [SW-1:0]     shift_word, shift_word_next, shift_in;
  logic [7:0]        pending_cmd, pending_cmd_next;
  logic              cmd_pending, cmd_pending_next;
  logic              drain, drain_next;
  logic [9:0]        holdoff_count, holdoff_count_next;
  logic [9:0]        timeout_count, timeout_count_next, timeout_dec;
  logic [15:0]       index_reg, index_reg_next;
  logic              leave_flag, leave_flag_next;
  logic              reinit_flag, reinit_flag_next;
  logic [ostwi_pkg::RAW_W-1:0]  raw_reg, raw_reg_next;
  logic [ostwi_pkg::CODE_W-1:0] code;
  logic [31:0]       shift_ext;
  logic [15:0]       read_load, write_load;
  logic              word_valid, index_valid, pen_timeout;
  logic              sck, drv, en;

  assign pop = head_valid && (!out_valid || !out_stall);

  assign read_load  = (cfg.read_half_ticks == 16'd0) ? 16'd0 : cfg.read_half_ticks - 16'd1;
  assign write_load = (cfg.write_half_ticks == 16'd0) ? 16'd0 : cfg.write_half_ticks - 16'd1;
  assign bc_inc     = bit_count + 1'b1;
  assign shift_in   = {shift_word[SW-2:0], head.sdio_in};
  assign shift_ext  = 32'(shift_in);
  assign timeout_dec = timeout_count - 10'd1;

  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    tick_count_next    = tick_count;
    shift_word_next    = shift_word;
    pending_cmd_next   = pending_cmd;
    cmd_pending_next   = cmd_pending;
    drain_next         = drain;
    holdoff_count_next = holdoff_count;
    timeout_count_next = timeout_count;
    index_reg_next     = index_reg;
    leave_flag_next    = leave_flag;
    reinit_flag_next   = reinit_flag;
    raw_reg_next       = raw_reg;
    code               = raw_reg[ostwi_pkg::CODE_W-1:0];
    word_valid         = 1'b0;
    index_valid        = 1'b0;
    pen_timeout        = 1'b0;

    if (head.ms_tick) begin
      if (holdoff_count != 10'd0) begin
        holdoff_count_next = holdoff_count - 10'd1;
      end
      if (timeout_count != 10'd0) begin
        if (timeout_dec == 10'd0) begin
          pen_timeout        = 1'b1;
          timeout_count_next = cfg.timeout_ms;
        end else begin
          timeout_count_next = timeout_dec;
        end
      end
    end
    if (head.req_type) begin
      pending_cmd_next = head.cmd_byte;
      cmd_pending_next = 1'b1;
    end

    if (phase == ostwi_pkg::PH_IDLE) begin
      if (cmd_pending_next) begin
        if (!head.sdio_in) begin
          drain_next      = 1'b1;
          shift_word_next = '0;
          bit_count_next  = '0;
          phase_next      = ostwi_pkg::PH_R_PRE;
          tick_count_next = read_load;
        end else begin
          shift_word_next  = SW'(pending_cmd_next);
          cmd_pending_next = 1'b0;
          bit_count_next   = '0;
          phase_next       = ostwi_pkg::PH_W_PRE;
          tick_count_next  = write_load;
        end
      end else if (holdoff_count_next == 10'd0 && !head.sdio_in) begin
        drain_next      = 1'b0;
        shift_word_next = '0;
        bit_count_next  = '0;
        phase_next      = ostwi_pkg::PH_R_PRE;
        tick_count_next = read_load;
      end
    end else if (tick_count != 16'd0) begin
      tick_count_next = tick_count - 16'd1;
    end else begin
      unique case (phase)
        ostwi_pkg::PH_R_PRE: begin
          phase_next      = ostwi_pkg::PH_R_SHI;
          tick_count_next = read_load;
        end
        ostwi_pkg::PH_R_SHI: begin
          phase_next      = ostwi_pkg::PH_R_SLO;
          tick_count_next = read_load;
        end
        ostwi_pkg::PH_R_SLO, ostwi_pkg::PH_R_BLO: begin
          if (phase == ostwi_pkg::PH_R_SLO) begin
            phase_next      = ostwi_pkg::PH_R_BHI;
            tick_count_next = read_load;
          end else begin
            shift_word_next = shift_in;
            bit_count_next  = bc_inc;
            if (bc_inc < BCW'(READ_BITS)) begin
              phase_next      = ostwi_pkg::PH_R_BHI;
              tick_count_next = read_load;
            end else begin
              raw_reg_next = shift_ext[ostwi_pkg::RAW_W-1:0];
              code         = shift_ext[ostwi_pkg::CODE_W-1:0];
              word_valid   = 1'b1;
              if (shift_ext[ostwi_pkg::RAW_W-1:0] == cfg.power_down_code) begin
                reinit_flag_next = 1'b1;
              end
              if (drain) begin
                drain_next       = 1'b0;
                shift_word_next  = SW'(pending_cmd_next);
                cmd_pending_next = 1'b0;
                bit_count_next   = '0;
                phase_next       = ostwi_pkg::PH_W_PRE;
                tick_count_next  = write_load;
              end else begin
                phase_next         = ostwi_pkg::PH_IDLE;
                holdoff_count_next = cfg.holdoff_ms;
                if (shift_ext[22] && !shift_ext[21]) begin
                  if (code == cfg.dont_care_code) begin
                    leave_flag_next = leave_flag;
                  end else if (code >= cfg.missing_min && code <= cfg.missing_max) begin
                    leave_flag_next = 1'b1;
                  end else if (code[17:16] == 2'd0) begin
                    index_reg_next     = code[15:0];
                    leave_flag_next    = 1'b0;
                    index_valid        = 1'b1;
                    timeout_count_next = cfg.timeout_ms;
                  end
                end else begin
                  leave_flag_next = 1'b1;
                end
              end
            end
          end
        end
        ostwi_pkg::PH_R_BHI: begin
          phase_next      = ostwi_pkg::PH_R_BLO;
          tick_count_next = read_load;
        end
        ostwi_pkg::PH_W_PRE: begin
          phase_next      = ostwi_pkg::PH_W_SHI;
          tick_count_next = write_load;
        end
        ostwi_pkg::PH_W_SHI: begin
          phase_next      = ostwi_pkg::PH_W_SLO;
          tick_count_next = write_load;
        end
        ostwi_pkg::PH_W_SLO: begin
          phase_next      = ostwi_pkg::PH_W_BHI;
          tick_count_next = write_load;
        end
        ostwi_pkg::PH_W_BHI: begin
          phase_next      = ostwi_pkg::PH_W_BLO;
          tick_count_next = write_load;
        end
        ostwi_pkg::PH_W_BLO: begin
          if (bc_inc < BCW'(ostwi_pkg::CMD_BITS)) begin
            bit_count_next  = bc_inc;
            shift_word_next = SW'({shift_word[6:0], 1'b0});
            phase_next      = ostwi_pkg::PH_W_BHI;
          end else begin
            bit_count_next = '0;
            phase_next     = ostwi_pkg::PH_W_GAP;
          end
          tick_count_next = write_load;
        end
        ostwi_pkg::PH_W_GAP: begin
          if (bc_inc < BCW'(ostwi_pkg::GAP_PERIODS)) begin
            bit_count_next  = bc_inc;
            phase_next      = ostwi_pkg::PH_W_GAP;
            tick_count_next = write_load;
          end else begin
            bit_count_next = '0;
            phase_next     = ostwi_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = ostwi_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    sck = 1'b0;
    drv = 1'b0;
    en  = 1'b0;
    case (phase_next)
      ostwi_pkg::PH_R_SHI: begin
        sck = 1'b1;
        en  = 1'b1;
      end
      ostwi_pkg::PH_R_SLO: begin
        en = 1'b1;
      end
      ostwi_pkg::PH_R_BHI, ostwi_pkg::PH_W_SHI: begin
        sck = 1'b1;
      end
      ostwi_pkg::PH_W_BHI: begin
        sck = 1'b1;
        en  = 1'b1;
        drv = shift_word_next[7];
      end
      ostwi_pkg::PH_W_BLO, ostwi_pkg::PH_W_GAP: begin
        en  = 1'b1;
        drv = shift_word_next[7];
      end
      default: begin
        sck = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ostwi_pkg::PH_IDLE;
      bit_count     <= '0;
      tick_count    <= 16'd0;
      shift_word    <= '0;
      pending_cmd   <= 8'd0;
      cmd_pending   <= 1'b0;
      drain         <= 1'b0;
      holdoff_count <= 10'd0;
      timeout_count <= 10'd0;
      index_reg     <= 16'd0;
      leave_flag    <= 1'b1;
      reinit_flag   <= 1'b0;
      raw_reg       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        tick_count    <= tick_count_next;
        shift_word    <= shift_word_next;
        pending_cmd   <= pending_cmd_next;
        cmd_pending   <= cmd_pending_next;
        drain         <= drain_next;
        holdoff_count <= holdoff_count_next;
        timeout_count <= timeout_count_next;
        index_reg     <= index_reg_next;
        leave_flag    <= leave_flag_next;
        reinit_flag   <= reinit_flag_next;
        raw_reg       <= raw_reg_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.sck_level     <= sck;
      res.sdio_drive    <= drv;
      res.sdio_enable   <= en;
      res.busy_res      <= (phase_next != ostwi_pkg::PH_IDLE);
      res.word_valid    <= word_valid;
      res.raw_word      <= raw_reg_next;
      res.index_valid   <= index_valid;
      res.pen_index     <= index_reg_next;
      res.pen_leave     <= leave_flag_next;
      res.pen_timeout   <= pen_timeout;
      res.reinit_needed <= reinit_flag_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/oid_sensor_two_wire_interface.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Host controller for a two-wire optical-ID pen sensor. Each input transaction is one
// clock tick of the link: it may carry a command byte to write, the sampled data line
// level and a millisecond pulse. Each input transaction yields exactly one result
// transaction with the levels to drive on the serial clock and data lines and the
// decoded pen status. One transaction is processed per cycle unless a stall holds the
// flow; the link sequencer takes one step per transaction. A two-entry input queue feeds
// the sequencer and a result register holds its output, so each transaction passes
// through the queue and then the result register. Configuration registers may be
// written only while no transaction is in flight.
module oid_sensor_two_wire_interface #(
  parameter int READ_BITS = ostwi_pkg::READ_BITS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     cfg_wr_en,
  input  wire  [ostwi_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [ostwi_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire                                     req_type,
  input  wire  [7:0]                              cmd_byte,
  input  wire                                     sdio_in,
  input  wire                                     ms_tick,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic                                    sck_level,
  output logic                                    sdio_drive,
  output logic                                    sdio_enable,
  output logic                                    busy_res,
  output logic                                    word_valid,
  output logic [ostwi_pkg::RAW_W-1:0]             raw_word,
  output logic                                    index_valid,
  output logic [ostwi_pkg::INDEX_W-1:0]           pen_index,
  output logic                                    pen_leave,
  output logic                                    pen_timeout,
  output logic                                    reinit_needed
);

  ostwi_pkg::cfg_t  cfg;
  ostwi_pkg::item_t item;
  ostwi_pkg::item_t head;
  ostwi_pkg::res_t  res;
  logic             head_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_half_ticks  <= 16'd300;
      cfg.write_half_ticks <= 16'd1000;
      cfg.holdoff_ms       <= 10'd30;
      cfg.timeout_ms       <= 10'd100;
      cfg.dont_care_code   <= '0;
      cfg.missing_min      <= '0;
      cfg.missing_max      <= '0;
      cfg.power_down_code  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ostwi_pkg::CFG_READ_HALF:  cfg.read_half_ticks  <= cfg_data[15:0];
        ostwi_pkg::CFG_WRITE_HALF: cfg.write_half_ticks <= cfg_data[15:0];
        ostwi_pkg::CFG_HOLDOFF:    cfg.holdoff_ms       <= cfg_data[9:0];
        ostwi_pkg::CFG_TIMEOUT:    cfg.timeout_ms       <= cfg_data[9:0];
        ostwi_pkg::CFG_DONT_CARE:  cfg.dont_care_code   <= cfg_data[ostwi_pkg::CODE_W-1:0];
        ostwi_pkg::CFG_MISS_MIN:   cfg.missing_min      <= cfg_data[ostwi_pkg::CODE_W-1:0];
        ostwi_pkg::CFG_MISS_MAX:   cfg.missing_max      <= cfg_data[ostwi_pkg::CODE_W-1:0];
        ostwi_pkg::CFG_POWER_DOWN: cfg.power_down_code  <= cfg_data[ostwi_pkg::RAW_W-1:0];
        default: begin
          cfg.holdoff_ms <= cfg.holdoff_ms;
        end
      endcase
    end
  end

  assign item.req_type = req_type;
  assign item.cmd_byte = cmd_byte;
  assign item.sdio_in  = sdio_in;
  assign item.ms_tick  = ms_tick;

  ostwi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ostwi_back #(
    .READ_BITS (READ_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .res        (res)
  );

  assign sck_level     = res.sck_level;
  assign sdio_drive    = res.sdio_drive;
  assign sdio_enable   = res.sdio_enable;
  assign busy_res      = res.busy_res;
  assign word_valid    = res.word_valid;
  assign raw_word      = res.raw_word;
  assign index_valid   = res.index_valid;
  assign pen_index     = res.pen_index;
  assign pen_leave     = res.pen_leave;
  assign pen_timeout   = res.pen_timeout;
  assign reinit_needed = res.reinit_needed;

`ifndef SYNTHESIS
  // The data line is never driven high while the host has released it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !sdio_enable |-> !sdio_drive)
    else $error("data driven high while released");

  // A new index only comes from a completed read and always clears pen-leave.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && index_valid |-> word_valid && !pen_leave && !busy_res)
    else $error("index accepted outside a completed read");

  // The serial clock only rises during a transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && sck_level |-> busy_res)
    else $error("serial clock high while idle");
`endif

endmodule
`default_nettype wire
